[src/wrp_pkg.sv]
// Shared types and constants for the weighted random pick block.
// Depends on nothing; used by wrp_ctrl, wrp_dp and weighted_random_pick.
`timescale 1ns / 1ps

package wrp_pkg;

    localparam int RND_BITS      = 32;
    localparam int DIV_CNT_BITS  = $clog2(RND_BITS);
    localparam int SLOT_BITS     = 6;
    localparam int NEW_WT_BITS   = 8;
    localparam int DEFAULT_FIRST = 1;
    localparam int DEFAULT_LAST  = 50;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_RANGE = 2'd1,
        REQ_DRAW  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        RES_WRITTEN = 2'd0,
        RES_RANGE   = 2'd1,
        RES_DRAWN   = 2'd2,
        RES_EMPTY   = 2'd3
    } t_res;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic fill;
        logic dflt;
        logic wr_read;
        logic wr_update;
        logic div_step;
        logic walk;
        logic finish;
        t_res code;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic fill_last;
        logic div_last;
        logic hit;
        logic total_zero;
    } t_stat;

endpackage

[src/weighted_random_pick.sv]
// Top level of the weighted random pick (roulette wheel) block.
// Depends on wrp_pkg, wrp_ctrl and wrp_dp.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------
//  request   | start & !busy        | i_req_type, i_slot_number, i_new_weight,
//            |                      | i_range_start, i_range_end, i_random_word
//  result    | o_done (one cycle)   | o_status, o_drawn_number
//
// After acceptance a write passes through read and update states, a range reset
// writes one entry per cycle, an empty draw ends without leaving idle, and
// unknown types are dropped. Draw: bit-serial remainder of the random word,
// then a walk of one slot per cycle through the registered memory port until
// the running sum exceeds the remainder. Busy stays high during the reset fill.
// Results cannot be stalled; a new request may be accepted in the result cycle.
`timescale 1ns / 1ps

module weighted_random_pick
    import wrp_pkg::*;
#(
    parameter int TABLE_SIZE  = 64,
    parameter int WEIGHT_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_req_type,
    input  logic [SLOT_BITS-1:0]   i_slot_number,
    input  logic [NEW_WT_BITS-1:0] i_new_weight,
    input  logic [SLOT_BITS-1:0]   i_range_start,
    input  logic [SLOT_BITS-1:0]   i_range_end,
    input  logic [RND_BITS-1:0]    i_random_word,
    output logic                   o_done,
    output logic [1:0]             o_status,
    output logic [SLOT_BITS-1:0]   o_drawn_number
);

    t_cmd  cmd;
    t_stat stat;

    wrp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .busy       (busy)
    );

    wrp_dp #(
        .TABLE_SIZE  (TABLE_SIZE),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_slot_number  (i_slot_number),
        .i_new_weight   (i_new_weight),
        .i_range_start  (i_range_start),
        .i_range_end    (i_range_end),
        .i_random_word  (i_random_word),
        .o_stat         (stat),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_drawn_number (o_drawn_number)
    );

endmodule

[src/wrp_ctrl.sv]
// Sequencer for the weighted random pick block: init sweep, requests, draw walk.
// Depends on wrp_pkg.
`timescale 1ns / 1ps

module wrp_ctrl
    import wrp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic [1:0]  i_req_type,
    input  t_stat       i_stat,
    output t_cmd        o_cmd,
    output logic        busy
);

    typedef enum logic [6:0] {
        S_INIT = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_WRD  = 7'b0000100,
        S_WUP  = 7'b0001000,
        S_FILL = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_WALK = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.code = RES_WRITTEN;
        case (r_state)
            S_INIT: begin
                o_cmd.fill = 1'b1;
                o_cmd.dflt = 1'b1;
                if (i_stat.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    case (t_req'(i_req_type))
                        REQ_WRITE: n_state = S_WRD;
                        REQ_RANGE: n_state = S_FILL;
                        REQ_DRAW: begin
                            if (i_stat.total_zero) begin
                                o_cmd.finish = 1'b1;
                                o_cmd.code   = RES_EMPTY;
                            end else begin
                                n_state = S_DIV;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_WRD: begin
                o_cmd.wr_read = 1'b1;
                n_state = S_WUP;
            end
            S_WUP: begin
                o_cmd.wr_update = 1'b1;
                o_cmd.finish    = 1'b1;
                o_cmd.code      = RES_WRITTEN;
                n_state = S_IDLE;
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_stat.fill_last) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.code   = RES_RANGE;
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.hit) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.code   = RES_DRAWN;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

[src/wrp_dp.sv]
// Datapath: weight memory, running total, bit-serial modulo and slot walk.
// Depends on wrp_pkg; driven by wrp_ctrl commands.
`timescale 1ns / 1ps

module wrp_dp
    import wrp_pkg::*;
#(
    parameter int TABLE_SIZE  = 64,
    parameter int WEIGHT_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic [SLOT_BITS-1:0]   i_slot_number,
    input  logic [NEW_WT_BITS-1:0] i_new_weight,
    input  logic [SLOT_BITS-1:0]   i_range_start,
    input  logic [SLOT_BITS-1:0]   i_range_end,
    input  logic [RND_BITS-1:0]    i_random_word,
    output t_stat                  o_stat,
    output logic                   o_done,
    output logic [1:0]             o_status,
    output logic [SLOT_BITS-1:0]   o_drawn_number
);

    localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int TW = $clog2(TABLE_SIZE * ((1 << WEIGHT_BITS) - 1) + 1);
    localparam int CW = (AW > SLOT_BITS) ? AW : SLOT_BITS;

    logic [WEIGHT_BITS-1:0] mem [TABLE_SIZE];

    logic [SLOT_BITS-1:0]    r_slot, r_rs, r_re;
    logic [WEIGHT_BITS-1:0]  r_wnew, r_rdata;
    logic [RND_BITS-1:0]     r_rnd;
    logic [DIV_CNT_BITS-1:0] r_dcnt;
    logic [TW-1:0]           r_total, r_rem, r_sum;
    logic [AW-1:0]           r_cnt, r_didx;
    logic                    r_dv;
    logic                    r_done;
    logic [1:0]              r_status;
    logic [SLOT_BITS-1:0]    r_drawn;

    logic [CW-1:0]          rs_e, re_e, cnt_e;
    logic                   fill_one;
    logic                   slot_ok;
    logic [AW-1:0]          slot_idx;
    logic [AW-1:0]          raddr;
    logic                   we;
    logic [AW-1:0]          waddr;
    logic [WEIGHT_BITS-1:0] wdata;
    logic [TW:0]            div_try;
    logic [TW-1:0]          n_rem;
    logic [TW-1:0]          n_sum;
    logic [TW-1:0]          fill_base;

    // range bounds: default range during the init sweep
    assign rs_e  = i_cmd.dflt ? CW'(DEFAULT_FIRST) : CW'(r_rs);
    assign re_e  = i_cmd.dflt ? CW'(DEFAULT_LAST)  : CW'(r_re);
    assign cnt_e = CW'(r_cnt);
    assign fill_one = (rs_e <= re_e) && (cnt_e >= rs_e) && (cnt_e <= re_e);

    assign slot_ok  = (32'(r_slot) < TABLE_SIZE);
    assign slot_idx = AW'(r_slot);

    assign raddr = i_cmd.wr_read ? slot_idx : r_cnt;
    assign we    = i_cmd.fill || (i_cmd.wr_update && slot_ok);
    assign waddr = i_cmd.fill ? r_cnt : slot_idx;
    assign wdata = i_cmd.fill ? (fill_one ? WEIGHT_BITS'(1) : '0) : r_wnew;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    // restoring remainder, one random bit per cycle, msb first
    assign div_try = {r_rem, r_rnd[RND_BITS-1]};
    assign n_rem   = (div_try >= {1'b0, r_total}) ? TW'(div_try - {1'b0, r_total})
                                                  : TW'(div_try);

    assign n_sum     = r_sum + TW'(r_rdata);
    assign fill_base = (r_cnt == '0) ? '0 : r_total;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_slot <= i_slot_number;
            r_wnew <= WEIGHT_BITS'(i_new_weight);
            r_rs   <= i_range_start;
            r_re   <= i_range_end;
            r_rnd  <= i_random_word;
            r_rem  <= '0;
            r_dcnt <= '0;
            r_sum  <= '0;
        end else begin
            if (i_cmd.div_step) begin
                r_rem  <= n_rem;
                r_rnd  <= {r_rnd[RND_BITS-2:0], 1'b0};
                r_dcnt <= r_dcnt + 1'b1;
            end
            if (i_cmd.walk && r_dv) begin
                r_sum <= n_sum;
            end
        end
        if (i_cmd.fill) begin
            r_total <= fill_base + TW'(fill_one);
        end else if (i_cmd.wr_update && slot_ok) begin
            r_total <= r_total - TW'(r_rdata) + TW'(r_wnew);
        end
        r_didx <= r_cnt;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_dv   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cnt <= '0;
                r_dv  <= 1'b0;
            end else if (i_cmd.fill) begin
                r_cnt <= (r_cnt == AW'(TABLE_SIZE - 1)) ? '0 : r_cnt + 1'b1;
            end else if (i_cmd.walk) begin
                r_cnt <= r_cnt + 1'b1;
                r_dv  <= 1'b1;
            end
            r_done <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_status <= i_cmd.code;
            r_drawn  <= (i_cmd.code == RES_DRAWN) ? SLOT_BITS'(r_didx) : '0;
        end
    end

    assign o_stat.fill_last  = (r_cnt == AW'(TABLE_SIZE - 1));
    assign o_stat.div_last   = (r_dcnt == DIV_CNT_BITS'(RND_BITS - 1));
    assign o_stat.hit        = r_dv && (r_rem < n_sum);
    assign o_stat.total_zero = (r_total == '0);

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_drawn_number = r_drawn;

endmodule
